@@ src/mat4_vec4_transform_defines.svh @@
// assertion macros shared by the transform block
`ifndef MAT4_VEC4_TRANSFORM_DEFINES_SVH
`define MAT4_VEC4_TRANSFORM_DEFINES_SVH

// implication in the same cycle, off while reset is low
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// implication in the next cycle, off while reset is low
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

// implication that also holds around reset
`define ASSERT_PLAIN(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error("assertion failed: reset implication");

`endif

@@ src/mvt_pkg.sv @@
// shared types and constants for the 4x4 matrix-vector transform
`timescale 1ns / 1ps
`default_nettype none

package mvt_pkg;

    localparam int N       = 4;             // vector length and matrix order
    localparam int Q_W     = 32;            // Q16.16 word
    localparam int FRAC    = 16;            // fraction bits
    localparam int PROD_W  = 2 * Q_W;       // full product
    localparam int SUM_W   = PROD_W + 2;    // exact sum of four products
    localparam int REG_N   = 8;             // matrix registers
    localparam int REG_W   = 64;            // register width
    localparam int REG_IW  = $clog2(REG_N);
    localparam int ADDR_W  = $clog2(REG_N * (REG_W / 8));
    localparam int BYTE_IW = ADDR_W - REG_IW;

    typedef logic signed [Q_W-1:0]    t_q;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [SUM_W-1:0]  t_sum;
    typedef t_q   [N-1:0]             t_vec;
    typedef t_sum [N-1:0]             t_sums;
    typedef logic [REG_W-1:0]         t_mreg;

    // data handed from one cell to the next
    typedef struct packed {
        logic  vld;
        t_vec  vec;
        t_sums sum;
    } t_bus;

    localparam t_q Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam t_q Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

    // identity matrix, register 7 first
    localparam t_mreg [REG_N-1:0] MAT_RESET = {
        64'h0001_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0001_0000
    };

endpackage

`default_nettype wire

@@ src/mat4_vec4_transform.sv @@
// top level: 4x4 q16.16 matrix times vector stream, row of four column cells
//
//  channel        direction  handshake                   payload
//  s_axis         in         i_s_axis_tvalid/o_..tready  vec_x..vec_w, 128 bits
//  m_axis         out        o_m_axis_tvalid/i_..tready  out_x..out_w, 128 bits
//  apb config     in         psel/penable/pwrite/pready  eight 64-bit matrix registers
//
//  one item per cycle while the output does not stall; two registers per column cell
//  (multiply, then accumulate) in each of four cells, then the saturating output register.
//  reset restores the identity matrix and empties the chain and the output stage.
//  a stalled output parks one item in the skid entry; the chain then holds and
//  o_s_axis_tready drops until the skid entry drains.
`timescale 1ns / 1ps
`default_nettype none
`include "mat4_vec4_transform_defines.svh"

module mat4_vec4_transform (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // stream in
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    input  logic [4*32-1:0]              i_s_axis_tdata,  // vec_x, vec_y, vec_z, vec_w
    // stream out
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    output logic [4*32-1:0]              o_m_axis_tdata,  // out_x, out_y, out_z, out_w
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mvt_pkg::ADDR_W-1:0]   paddr,
    input  logic [mvt_pkg::REG_W-1:0]    pwdata,
    output logic [mvt_pkg::REG_W-1:0]    prdata,
    output logic                         pready
);
    import mvt_pkg::*;

    t_mreg             r_mat [REG_N];
    logic [REG_IW-1:0] w_ridx;
    logic              w_adv;
    t_bus              w_bus  [N+1];
    t_vec              w_coef [N];
    t_vec              w_res;

    // matrix registers, one 64-bit register per pair of columns
    assign w_ridx = paddr[ADDR_W-1:BYTE_IW];
    assign pready = 1'b1;
    assign prdata = r_mat[w_ridx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < REG_N; k++) begin
                r_mat[k] <= MAT_RESET[k];
            end
        end else if (psel && penable && pwrite && pready) begin
            r_mat[w_ridx] <= pwdata;
        end
    end

    // column j of the matrix for cell j
    for (genvar j = 0; j < N; j++) begin : g_col
        for (genvar r = 0; r < N; r++) begin : g_row
            assign w_coef[j][r] = r_mat[2*r + j/2][Q_W*(j%2) +: Q_W];
        end
    end

    // chain entry: accepted item with zero partial sums
    assign o_s_axis_tready = w_adv;
    assign w_bus[0] = '{vld: i_s_axis_tvalid && w_adv,
                        vec: t_vec'(i_s_axis_tdata),
                        sum: '0};

    for (genvar j = 0; j < N; j++) begin : g_cell
        mvt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_coef  (w_coef[j]),
            .i_bus   (w_bus[j]),
            .o_bus   (w_bus[j+1])
        );
    end

    mvt_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_bus      (w_bus[N]),
        .i_m_tready (i_m_axis_tready),
        .o_adv      (w_adv),
        .o_m_tvalid (o_m_axis_tvalid),
        .o_m_tdata  (w_res)
    );

    assign o_m_axis_tdata = w_res;

    // a full skid entry means the output register holds an item too
    `ASSERT_IMPL(a_skid_behind_out, i_clk, i_rst_n, !o_s_axis_tready, o_m_axis_tvalid)
    // the input side only closes after an output stall
    `ASSERT_NEXT(a_ready_holds, i_clk, i_rst_n,
                 o_s_axis_tready && !(o_m_axis_tvalid && !i_m_axis_tready), o_s_axis_tready)
    // nothing leaves in the cycle after reset
    `ASSERT_PLAIN(a_reset_empty, i_clk, $past(!i_rst_n), !o_m_axis_tvalid && o_s_axis_tready)

endmodule

`default_nettype wire

@@ src/mvt_cell.sv @@
// one column cell: multiplies vector component 0 by a matrix column and accumulates
`timescale 1ns / 1ps
`default_nettype none

module mvt_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  mvt_pkg::t_vec i_coef,   // column entries, row 0 in the lowest bits
    input  mvt_pkg::t_bus i_bus,
    output mvt_pkg::t_bus o_bus
);
    import mvt_pkg::*;

    t_prod r_prod [N];
    t_sums r_sum_a;
    t_vec  r_vec_a;
    logic  r_vld_a;
    t_sums r_sum_b;
    t_sums n_sum_b;
    t_vec  r_vec_b;
    logic  r_vld_b;

    // valid flags move with the chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
        end else if (i_en) begin
            r_vld_a <= i_bus.vld;
            r_vld_b <= r_vld_a;
        end
    end

    // add each product to the partial sum coming in
    always_comb begin
        for (int i = 0; i < N; i++) begin
            n_sum_b[i] = $signed(r_sum_a[i]) + $signed(t_sum'(r_prod[i]));
        end
    end

    // stage a: products, stage b: sums; the used component drops out of the vector
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < N; i++) begin
                r_prod[i] <= $signed(i_coef[i]) * $signed(i_bus.vec[0]);
            end
            r_sum_a <= i_bus.sum;
            r_vec_a <= {t_q'(0), i_bus.vec[N-1:1]};
            r_sum_b <= n_sum_b;
            r_vec_b <= r_vec_a;
        end
    end

    assign o_bus = '{vld: r_vld_b, vec: r_vec_b, sum: r_sum_b};

endmodule

`default_nettype wire

@@ src/mvt_out.sv @@
// output stage: shift and saturate, output register with skid entry
`timescale 1ns / 1ps
`default_nettype none

module mvt_out (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mvt_pkg::t_bus        i_bus,
    input  logic                 i_m_tready,
    output logic                 o_adv,
    output logic                 o_m_tvalid,
    output mvt_pkg::t_vec        o_m_tdata
);
    import mvt_pkg::*;

    t_vec n_res;
    t_vec r_out;
    t_vec r_skid;
    logic r_out_vld;
    logic r_skid_vld;
    logic n_out_vld;
    logic n_skid_vld;
    logic w_load;
    logic w_out_ld;
    logic w_out_from_skid;
    logic w_skid_ld;

    // floor shift by the fraction bits, then clamp to the q16.16 range
    function automatic t_q sat_q(input t_sum s);
        logic [SUM_W-Q_W-FRAC:0] top;
        top = s[SUM_W-1:Q_W+FRAC-1];
        if ((&top) || !(|top)) begin
            return s[Q_W+FRAC-1:FRAC];
        end
        return s[SUM_W-1] ? Q_MIN : Q_MAX;
    endfunction

    always_comb begin
        for (int i = 0; i < N; i++) begin
            n_res[i] = sat_q(i_bus.sum[i]);
        end
    end

    // the chain moves whenever the skid entry is free
    assign o_adv  = !r_skid_vld;
    assign w_load = o_adv && i_bus.vld;

    // output register and skid entry control
    always_comb begin
        n_out_vld       = r_out_vld;
        n_skid_vld      = r_skid_vld;
        w_out_ld        = 1'b0;
        w_out_from_skid = 1'b0;
        w_skid_ld       = 1'b0;
        if (!r_out_vld || i_m_tready) begin
            if (r_skid_vld) begin
                n_out_vld       = 1'b1;
                n_skid_vld      = 1'b0;
                w_out_ld        = 1'b1;
                w_out_from_skid = 1'b1;
            end else begin
                n_out_vld = w_load;
                w_out_ld  = w_load;
            end
        end else if (w_load) begin
            n_skid_vld = 1'b1;
            w_skid_ld  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_out_vld  <= n_out_vld;
            r_skid_vld <= n_skid_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_ld) begin
            r_out <= w_out_from_skid ? r_skid : n_res;
        end
        if (w_skid_ld) begin
            r_skid <= n_res;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out;

endmodule

`default_nettype wire
